// ===== hw/rtl/rtsb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rtsb_pkg;

  // Defaults for the top-level parameters.
  localparam int SECTOR_WIDTH_DEF  = 64;
  localparam int SECTOR_HEIGHT_DEF = 64;
  localparam int MAX_LANDSCAPE_DEF = 4096;
  localparam int MAX_RUN_DEF       = 64;
  localparam int MUL_W_DEF         = 16;

  // Fixed field widths.
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 1;
  localparam int COORD_W   = 16;
  localparam int IDX_W     = 12;
  localparam int CR_W      = 6;

  localparam logic [CFG_W-1:0] LANDSCAPE_RESET = 13'd4096;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_LANDSCAPE_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LANDSCAPE_HEIGHT = 1'd1;

  typedef struct packed {
    logic signed [COORD_W-1:0] rect_left;
    logic signed [COORD_W-1:0] rect_top;
    logic signed [COORD_W-1:0] rect_width;
    logic signed [COORD_W-1:0] rect_height;
  } rect_t;

  typedef struct packed {
    logic [IDX_W-1:0] sector_index;
    logic [CR_W-1:0]  sector_column;
    logic [CR_W-1:0]  sector_row;
    logic             outside;
    logic             last;
    logic             truncated;
  } sector_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLIP,
    ST_DIV_EST,
    ST_DIV_BACK,
    ST_DIV_FIX,
    ST_BASE,
    ST_LOAD,
    ST_WALK,
    ST_OUTS
  } rtsb_state_t;

  // Which quotient the shared divide sequence is working on.
  typedef enum logic [2:0] {
    DIV_COLS,
    DIV_COL0,
    DIV_COL1,
    DIV_ROW0,
    DIV_ROW1
  } div_sel_t;

endpackage

`default_nettype wire

// ===== hw/rtl/rtsb_mul.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Shared unsigned multiplier with a registered product.
module rtsb_mul #(
  parameter int AW = rtsb_pkg::MUL_W_DEF,
  parameter int BW = rtsb_pkg::MUL_W_DEF
) (
  input  wire logic             clk,
  input  wire logic             en,
  input  wire logic [AW-1:0]    a,
  input  wire logic [BW-1:0]    b,
  output logic      [AW+BW-1:0] prod
);

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= (AW+BW)'(a) * (AW+BW)'(b);
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/rect_to_sector_binning.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake                  Payload
// cfg       in         cfg_we                     cfg_index, cfg_data
// rect      in         rect_valid / rect_stall    rect   (rtsb_pkg::rect_t)
// sector    out        sector_valid / sector_stall sector (rtsb_pkg::sector_t)
//
// A rectangle whose clipped origin is off the landscape goes from clipping
// straight to its single result. Any other rectangle goes through clipping,
// five divisions by the sector size on the one shared multiplier (estimate,
// back-multiply and fix for each), the row base multiply and a load, then one
// result per cycle unless the sector channel stalls. The block takes the
// next rectangle once the last result sits in the output register. Reset is
// synchronous and active high; it clears the sequencer and the output valid and
// loads both landscape sizes with 4096. A sector stall holds the walk in place.

module rect_to_sector_binning #(
  parameter int SECTOR_WIDTH  = rtsb_pkg::SECTOR_WIDTH_DEF,
  parameter int SECTOR_HEIGHT = rtsb_pkg::SECTOR_HEIGHT_DEF,
  parameter int MAX_LANDSCAPE = rtsb_pkg::MAX_LANDSCAPE_DEF,
  parameter int MAX_RUN       = rtsb_pkg::MAX_RUN_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [rtsb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [rtsb_pkg::CFG_W-1:0]      cfg_data,
  input  wire logic                            rect_valid,
  output logic                                 rect_stall,
  input  wire rtsb_pkg::rect_t                 rect,
  output logic                                 sector_valid,
  input  wire logic                            sector_stall,
  output rtsb_pkg::sector_t                    sector
);

  // Landscape size width: holds MAX_LANDSCAPE itself.
  localparam int LW    = $clog2(MAX_LANDSCAPE) + 1;
  // Sector coordinate width.
  localparam int QW    = LW - 1;
  // Multiplier operand width; must also hold the sector size.
  localparam int OPW   = (LW > 10) ? LW : 10;
  localparam int PW    = 2 * OPW;
  localparam int XW    = (LW > rtsb_pkg::IDX_W) ? LW : rtsb_pkg::IDX_W;
  localparam int CNT_W = $clog2(MAX_RUN + 1);
  // Signed width for the normalized edges.
  localparam int SW    = 18;
  // Reciprocals scaled by 2^LW; the estimate is exact or one low.
  localparam int MX    = (1 << LW) / SECTOR_WIDTH;
  localparam int MY    = (1 << LW) / SECTOR_HEIGHT;

  localparam logic [OPW-1:0]   DX      = OPW'(SECTOR_WIDTH);
  localparam logic [OPW-1:0]   DY      = OPW'(SECTOR_HEIGHT);
  localparam logic [OPW-1:0]   RCP_X   = OPW'(MX);
  localparam logic [OPW-1:0]   RCP_Y   = OPW'(MY);
  localparam logic [CNT_W-1:0] RUN_CAP = CNT_W'(MAX_RUN - 1);

  // Configuration registers.
  logic [rtsb_pkg::CFG_W-1:0] land_w;
  logic [rtsb_pkg::CFG_W-1:0] land_h;

  always_ff @(posedge clk) begin
    if (rst) begin
      land_w <= rtsb_pkg::LANDSCAPE_RESET;
      land_h <= rtsb_pkg::LANDSCAPE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        rtsb_pkg::REG_LANDSCAPE_WIDTH:  land_w <= cfg_data;
        rtsb_pkg::REG_LANDSCAPE_HEIGHT: land_h <= cfg_data;
        default: ;
      endcase
    end
  end

  // Effective landscape size, held to the range 1 .. MAX_LANDSCAPE.
  logic [LW-1:0] pw;
  logic [LW-1:0] ph;

  always_comb begin
    if (land_w == '0) begin
      pw = LW'(1);
    end else if (32'(land_w) > 32'(MAX_LANDSCAPE)) begin
      pw = LW'(MAX_LANDSCAPE);
    end else begin
      pw = LW'(land_w);
    end
    if (land_h == '0) begin
      ph = LW'(1);
    end else if (32'(land_h) > 32'(MAX_LANDSCAPE)) begin
      ph = LW'(MAX_LANDSCAPE);
    end else begin
      ph = LW'(land_h);
    end
  end

  // Sequencer state and datapath registers.
  rtsb_pkg::rtsb_state_t state, state_next;
  rtsb_pkg::div_sel_t    div_sel;

  logic signed [SW-1:0] x_n, y_n, x_e, y_e;
  logic                 outs;
  logic [LW-1:0]        dvd_cols, dvd_c0, dvd_c1, dvd_r0, dvd_r1;
  logic [QW-1:0]        q_est;
  logic [LW-1:0]        cols;
  logic [QW-1:0]        c0, c1, r0, r1;
  logic [QW-1:0]        walk_c, walk_r;
  logic [rtsb_pkg::IDX_W-1:0] row_base;
  logic [CNT_W-1:0]     count;

  // Input normalization: a negative size moves the near edge and flips sign.
  logic signed [SW-1:0] in_x, in_y, in_w, in_h, in_xn, in_yn, in_wn, in_hn;

  always_comb begin
    in_x  = SW'(rect.rect_left);
    in_y  = SW'(rect.rect_top);
    in_w  = SW'(rect.rect_width);
    in_h  = SW'(rect.rect_height);
    in_xn = (in_w < 0) ? in_x + in_w : in_x;
    in_wn = (in_w < 0) ? -in_w : in_w;
    in_yn = (in_h < 0) ? in_y + in_h : in_y;
    in_hn = (in_h < 0) ? -in_h : in_h;
  end

  // Clipping against the landscape. When the rectangle lies wholly inside, the
  // clamps change nothing, so they are applied every time.
  logic signed [SW-1:0] pw_s, ph_s, clip_l, clip_r, clip_t, clip_b;
  logic signed [SW-1:0] clip_c1, clip_r1;
  logic                 clip_outs, origin_out;

  always_comb begin
    pw_s       = SW'(pw);
    ph_s       = SW'(ph);
    clip_l     = (x_n < 0) ? '0 : x_n;
    clip_t     = (y_n < 0) ? '0 : y_n;
    clip_r     = (x_e < pw_s) ? x_e : pw_s;
    clip_b     = (y_e < ph_s) ? y_e : ph_s;
    clip_outs  = (x_n < 0) || (y_n < 0) || (x_e > pw_s) || (y_e > ph_s);
    origin_out = (clip_l >= pw_s) || (clip_t >= ph_s);
    // A clipped size of zero counts as one pixel, so the far pixel is the origin.
    clip_c1    = (clip_r > clip_l) ? clip_r - SW'(1) : clip_l;
    clip_r1    = (clip_b > clip_t) ? clip_b - SW'(1) : clip_t;
  end

  // Shared multiplier.
  logic           mul_en;
  logic [OPW-1:0] mul_a, mul_b;
  logic [PW-1:0]  prod;

  rtsb_mul #(
    .AW (OPW),
    .BW (OPW)
  ) u_mul (
    .clk  (clk),
    .en   (mul_en),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  // Operands of the division in progress.
  logic [LW-1:0]  div_dvd;
  logic [OPW-1:0] div_d, div_rcp, div_rem;
  logic [QW-1:0]  div_q;

  always_comb begin
    case (div_sel)
      rtsb_pkg::DIV_COLS: div_dvd = dvd_cols;
      rtsb_pkg::DIV_COL0: div_dvd = dvd_c0;
      rtsb_pkg::DIV_COL1: div_dvd = dvd_c1;
      rtsb_pkg::DIV_ROW0: div_dvd = dvd_r0;
      rtsb_pkg::DIV_ROW1: div_dvd = dvd_r1;
      default:            div_dvd = dvd_cols;
    endcase
    if ((div_sel == rtsb_pkg::DIV_ROW0) || (div_sel == rtsb_pkg::DIV_ROW1)) begin
      div_d   = DY;
      div_rcp = RCP_Y;
    end else begin
      div_d   = DX;
      div_rcp = RCP_X;
    end
    // The estimate is never high, so the remainder lies in [0, 2 * size).
    div_rem = OPW'(div_dvd) - prod[OPW-1:0];
    div_q   = q_est + QW'(div_rem >= div_d);
  end

  // Walk bookkeeping and the result that would be presented this cycle.
  logic              emit_ok, emit, at_final, at_cap;
  logic [XW-1:0]     idx_sum;
  rtsb_pkg::sector_t emit_data;

  assign emit_ok = !sector_valid || !sector_stall;

  always_comb begin
    state_next = state;
    emit       = 1'b0;
    emit_data  = '0;
    mul_en     = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    at_final   = (walk_c == c1) && (walk_r == r1);
    at_cap     = (count == RUN_CAP);
    idx_sum    = XW'(row_base) + XW'(walk_c);
    case (state)
      rtsb_pkg::ST_IDLE: begin
        if (rect_valid) begin
          state_next = rtsb_pkg::ST_CLIP;
        end
      end
      rtsb_pkg::ST_CLIP: begin
        state_next = origin_out ? rtsb_pkg::ST_OUTS : rtsb_pkg::ST_DIV_EST;
      end
      rtsb_pkg::ST_DIV_EST: begin
        mul_en     = 1'b1;
        mul_a      = OPW'(div_dvd);
        mul_b      = div_rcp;
        state_next = rtsb_pkg::ST_DIV_BACK;
      end
      rtsb_pkg::ST_DIV_BACK: begin
        mul_en     = 1'b1;
        mul_a      = OPW'(prod[LW +: QW]);
        mul_b      = div_d;
        state_next = rtsb_pkg::ST_DIV_FIX;
      end
      rtsb_pkg::ST_DIV_FIX: begin
        state_next = (div_sel == rtsb_pkg::DIV_ROW1) ? rtsb_pkg::ST_BASE
                                                     : rtsb_pkg::ST_DIV_EST;
      end
      rtsb_pkg::ST_BASE: begin
        mul_en     = 1'b1;
        mul_a      = OPW'(r0);
        mul_b      = OPW'(cols);
        state_next = rtsb_pkg::ST_LOAD;
      end
      rtsb_pkg::ST_LOAD: begin
        state_next = rtsb_pkg::ST_WALK;
      end
      rtsb_pkg::ST_WALK: begin
        if (emit_ok) begin
          emit                    = 1'b1;
          emit_data.sector_index  = idx_sum[rtsb_pkg::IDX_W-1:0];
          emit_data.sector_column = walk_c[rtsb_pkg::CR_W-1:0];
          emit_data.sector_row    = walk_r[rtsb_pkg::CR_W-1:0];
          if (at_final && !outs) begin
            emit_data.last = 1'b1;
            state_next     = rtsb_pkg::ST_IDLE;
          end else if (at_cap) begin
            // The run is full; anything still to come, outside sector included,
            // is dropped.
            emit_data.last      = 1'b1;
            emit_data.truncated = 1'b1;
            state_next          = rtsb_pkg::ST_IDLE;
          end else if (at_final) begin
            state_next = rtsb_pkg::ST_OUTS;
          end
        end
      end
      rtsb_pkg::ST_OUTS: begin
        if (emit_ok) begin
          emit              = 1'b1;
          emit_data.outside = 1'b1;
          emit_data.last    = 1'b1;
          state_next        = rtsb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = rtsb_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rtsb_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign rect_stall = rst || (state != rtsb_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      div_sel <= rtsb_pkg::DIV_COLS;
    end else begin
      case (state)
        rtsb_pkg::ST_CLIP: begin
          div_sel <= rtsb_pkg::DIV_COLS;
        end
        rtsb_pkg::ST_DIV_FIX: begin
          case (div_sel)
            rtsb_pkg::DIV_COLS: div_sel <= rtsb_pkg::DIV_COL0;
            rtsb_pkg::DIV_COL0: div_sel <= rtsb_pkg::DIV_COL1;
            rtsb_pkg::DIV_COL1: div_sel <= rtsb_pkg::DIV_ROW0;
            rtsb_pkg::DIV_ROW0: div_sel <= rtsb_pkg::DIV_ROW1;
            default:            div_sel <= rtsb_pkg::DIV_COLS;
          endcase
        end
        rtsb_pkg::ST_LOAD: begin
          count <= '0;
        end
        rtsb_pkg::ST_WALK: begin
          if (emit) begin
            count <= count + CNT_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // Payload registers of the sequencer.
  always_ff @(posedge clk) begin
    case (state)
      rtsb_pkg::ST_IDLE: begin
        if (rect_valid && !rect_stall) begin
          x_n <= in_xn;
          y_n <= in_yn;
          x_e <= in_xn + in_wn;
          y_e <= in_yn + in_hn;
        end
      end
      rtsb_pkg::ST_CLIP: begin
        outs     <= clip_outs;
        dvd_cols <= pw - LW'(1);
        dvd_c0   <= clip_l[LW-1:0];
        dvd_c1   <= clip_c1[LW-1:0];
        dvd_r0   <= clip_t[LW-1:0];
        dvd_r1   <= clip_r1[LW-1:0];
      end
      rtsb_pkg::ST_DIV_BACK: begin
        q_est <= prod[LW +: QW];
      end
      rtsb_pkg::ST_DIV_FIX: begin
        case (div_sel)
          rtsb_pkg::DIV_COLS: cols <= LW'(div_q) + LW'(1);
          rtsb_pkg::DIV_COL0: c0   <= div_q;
          rtsb_pkg::DIV_COL1: c1   <= div_q;
          rtsb_pkg::DIV_ROW0: r0   <= div_q;
          rtsb_pkg::DIV_ROW1: r1   <= div_q;
          default: ;
        endcase
      end
      rtsb_pkg::ST_LOAD: begin
        row_base <= prod[rtsb_pkg::IDX_W-1:0];
        walk_c   <= c0;
        walk_r   <= r0;
      end
      rtsb_pkg::ST_WALK: begin
        if (emit) begin
          if (walk_c == c1) begin
            walk_c   <= c0;
            walk_r   <= walk_r + QW'(1);
            row_base <= rtsb_pkg::IDX_W'(XW'(row_base) + XW'(cols));
          end else begin
            walk_c <= walk_c + QW'(1);
          end
        end
      end
      default: ;
    endcase
  end

  // Output register: refilled in the same cycle that its content transfers.
  always_ff @(posedge clk) begin
    if (rst) begin
      sector_valid <= 1'b0;
    end else if (emit) begin
      sector_valid <= 1'b1;
    end else if (!sector_stall) begin
      sector_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      sector <= emit_data;
    end
  end

  // A transfer on the rect channel starts a run, so the block holds off the next
  // rectangle in the following cycle.
  assert property (@(posedge clk) disable iff (rst)
    (rect_valid && !rect_stall) |=> rect_stall)
    else $error("rectangle transfer did not start a run");

  // The outside sector always closes its run.
  assert property (@(posedge clk) disable iff (rst)
    (sector_valid && sector.outside) |-> sector.last)
    else $error("outside sector is not the last result");

  // A truncated run ends on an inside sector.
  assert property (@(posedge clk) disable iff (rst)
    (sector_valid && sector.truncated) |-> (sector.last && !sector.outside))
    else $error("truncated flag on a result that does not end the run");

  // The walk never produces more than the run cap.
  assert property (@(posedge clk) disable iff (rst)
    (count <= CNT_W'(MAX_RUN)))
    else $error("run exceeded its result cap");

endmodule

`default_nettype wire

// ===== tb/rect_to_sector_binning_test.sv =====
`timescale 1ns / 1ps

module rect_to_sector_binning_test;

  // The block runs with its default geometry, so the predictor uses the same numbers.
  localparam int SECTOR_W    = rtsb_pkg::SECTOR_WIDTH_DEF;
  localparam int SECTOR_H    = rtsb_pkg::SECTOR_HEIGHT_DEF;
  localparam int LAND_MAX    = rtsb_pkg::MAX_LANDSCAPE_DEF;
  localparam int RUN_CAP     = rtsb_pkg::MAX_RUN_DEF;
  // The longest correct quiet stretch is a long source gap, then the setup of a
  // run, then a long sink stall. This limit is many times that.
  localparam int IDLE_LIMIT  = 2000;
  localparam int TAIL_CYCLES = 40;
  localparam int PRINT_CAP   = 40;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           cfg_we = 1'b0;
  logic [rtsb_pkg::CFG_IDX_W-1:0] cfg_index = rtsb_pkg::REG_LANDSCAPE_WIDTH;
  logic [rtsb_pkg::CFG_W-1:0]     cfg_data = '0;
  logic                           rect_valid = 1'b0;
  logic                           rect_stall;
  rtsb_pkg::rect_t                rect = '0;
  logic                           sector_valid;
  logic                           sector_stall = 1'b0;
  rtsb_pkg::sector_t              sector;

  // Shadow copies of the landscape registers, as written by this bench.
  logic [rtsb_pkg::CFG_W-1:0] land_w = rtsb_pkg::LANDSCAPE_RESET;
  logic [rtsb_pkg::CFG_W-1:0] land_h = rtsb_pkg::LANDSCAPE_RESET;

  // Sectors that the block still owes, oldest first.
  rtsb_pkg::sector_t pending_sectors[$];

  int error_count = 0;
  int sector_count = 0;
  int idle_count = 0;
  int stall_hold = 0;
  // When set, neither side inserts gaps, so transfers run back to back.
  bit no_idle = 1'b0;

  rect_to_sector_binning DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .rect_valid   (rect_valid),
    .rect_stall   (rect_stall),
    .rect         (rect),
    .sector_valid (sector_valid),
    .sector_stall (sector_stall),
    .sector       (sector)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Every failure goes through here. Only the first few are printed so that a
  // systematic fault does not flood the log, but all of them are counted.
  task automatic report_error(input string msg);
    if (error_count < PRINT_CAP) begin
      $display("ERROR @%0t: %s", $time, msg);
    end
    error_count++;
  endtask

  // Register values outside the legal range are clamped the same way the block does.
  function automatic int land_px(input logic [rtsb_pkg::CFG_W-1:0] v);
    if (v < 1) return 1;
    if (v > LAND_MAX) return LAND_MAX;
    return int'(v);
  endfunction

  function automatic rtsb_pkg::sector_t make_sector(input int idx, input int col,
                                                    input int row, input bit outs);
    rtsb_pkg::sector_t s;
    s.sector_index  = idx[rtsb_pkg::IDX_W-1:0];
    s.sector_column = col[rtsb_pkg::CR_W-1:0];
    s.sector_row    = row[rtsb_pkg::CR_W-1:0];
    s.outside       = outs;
    s.last          = 1'b0;
    s.truncated     = 1'b0;
    return s;
  endfunction

  // Works out the sectors that one rectangle covers under the current landscape
  // and queues them in the order the block must produce them.
  function automatic void bin_rectangle(input rtsb_pkg::rect_t r);
    int x, y, w, h, pw, ph, cols, lft, rgt, top, bot, c0, c1, r0, r1, n;
    bit clipped, cut;
    rtsb_pkg::sector_t run[$];
    rtsb_pkg::sector_t s;
    x = $signed(r.rect_left);
    y = $signed(r.rect_top);
    w = $signed(r.rect_width);
    h = $signed(r.rect_height);
    pw = land_px(land_w);
    ph = land_px(land_h);
    cols = (pw - 1) / SECTOR_W + 1;
    clipped = 1'b0;
    cut = 1'b0;
    n = 0;

    // A negative size flips the rectangle about its left or top edge.
    if (w < 0) begin
      x += w;
      w = -w;
    end
    if (h < 0) begin
      y += h;
      h = -h;
    end

    // Anything that pokes out of the landscape is clamped to it and also gets
    // the outside sector appended.
    if (x < 0 || y < 0 || x + w > pw || y + h > ph) begin
      lft = (x > 0) ? x : 0;
      rgt = (x + w < pw) ? x + w : pw;
      top = (y > 0) ? y : 0;
      bot = (y + h < ph) ? y + h : ph;
      x = lft;
      w = (rgt - lft < 0) ? 0 : rgt - lft;
      y = top;
      h = (bot - top < 0) ? 0 : bot - top;
      clipped = 1'b1;
    end

    if (x < 0 || y < 0 || x >= pw || y >= ph) begin
      // The clipped corner is off the landscape: the outside sector stands alone.
      run.push_back(make_sector(0, 0, 0, 1'b1));
    end else begin
      // A zero-sized rectangle still covers the sector its corner sits in.
      if (w == 0) w = 1;
      if (h == 0) h = 1;
      c0 = x / SECTOR_W;
      c1 = (x + w - 1) / SECTOR_W;
      r0 = y / SECTOR_H;
      r1 = (y + h - 1) / SECTOR_H;
      for (int row = r0; row <= r1 && !cut; row++) begin
        for (int col = c0; col <= c1; col++) begin
          if (n >= RUN_CAP) begin
            cut = 1'b1;
            break;
          end
          run.push_back(make_sector(row * cols + col, col, row, 1'b0));
          n++;
        end
      end
      // The outside sector is dropped when the cap is already used up.
      if (clipped && !cut) begin
        if (n >= RUN_CAP) cut = 1'b1;
        else run.push_back(make_sector(0, 0, 0, 1'b1));
      end
    end

    s = run.pop_back();
    s.last = 1'b1;
    s.truncated = cut;
    run.push_back(s);
    foreach (run[i]) pending_sectors.push_back(run[i]);
  endfunction

  // Gap lengths: none half the time, often a few cycles, now and then a long one.
  function automatic int idle_length();
    int p;
    if (no_idle) return 0;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic rtsb_pkg::rect_t mk(input int l, input int t, input int w, input int h);
    rtsb_pkg::rect_t r;
    r.rect_left   = l[rtsb_pkg::COORD_W-1:0];
    r.rect_top    = t[rtsb_pkg::COORD_W-1:0];
    r.rect_width  = w[rtsb_pkg::COORD_W-1:0];
    r.rect_height = h[rtsb_pkg::COORD_W-1:0];
    return r;
  endfunction

  // Most random rectangles are small ones placed on the landscape, some straddle
  // an edge, some are large enough to hit the run cap, and the rest is raw noise.
  function automatic rtsb_pkg::rect_t random_rect();
    int pw, ph, kind, x, y, w, h;
    pw = land_px(land_w);
    ph = land_px(land_h);
    kind = $urandom_range(0, 99);
    if (kind >= 90) return rtsb_pkg::rect_t'({$urandom, $urandom});
    x = $urandom_range(0, pw - 1);
    y = $urandom_range(0, ph - 1);
    w = $urandom_range(0, 150);
    h = $urandom_range(0, 150);
    if (kind >= 60 && kind < 80) begin
      x = $urandom_range(0, pw + 199) - 100;
      y = $urandom_range(0, ph + 199) - 100;
    end else if (kind >= 80) begin
      w = $urandom_range(0, 700);
      h = $urandom_range(0, 700);
    end
    if ($urandom_range(0, 3) == 0) w = -w;
    if ($urandom_range(0, 3) == 0) h = -h;
    return mk(x, y, w, h);
  endfunction

  // Offers one rectangle and returns at the clock edge where its transfer
  // happens. When no gap follows, valid simply stays high for the next one.
  task automatic send_rect(input rtsb_pkg::rect_t r);
    int gap;
    gap = idle_length();
    if (gap > 0) begin
      rect_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rect_valid <= 1'b1;
    rect <= r;
    do @(posedge clk); while (rect_stall !== 1'b0);
    bin_rectangle(r);
  endtask

  // Every rectangle yields at least one sector, so once nothing is owed the
  // block is idle again; a few spare cycles are added anyway.
  task automatic wait_for_results();
    rect_valid <= 1'b0;
    while (pending_sectors.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_landscape(input logic [rtsb_pkg::CFG_W-1:0] wd,
                               input logic [rtsb_pkg::CFG_W-1:0] ht);
    wait_for_results();
    cfg_we    <= 1'b1;
    cfg_index <= rtsb_pkg::REG_LANDSCAPE_WIDTH;
    cfg_data  <= wd;
    @(posedge clk);
    cfg_index <= rtsb_pkg::REG_LANDSCAPE_HEIGHT;
    cfg_data  <= ht;
    @(posedge clk);
    cfg_we <= 1'b0;
    land_w = wd;
    land_h = ht;
  endtask

  // Corner cases on the reset landscape: degenerate sizes, flipped sizes, edge
  // crossings, corners off the landscape, and runs right at and over the cap.
  task automatic test_directed_cases();
    send_rect(mk(0, 0, 0, 0));
    send_rect(mk(-1, -1, -1, -1));
    send_rect(mk(0, 0, 1, 1));
    send_rect(mk(63, 63, 2, 2));
    send_rect(mk(4032, 4032, 64, 64));
    send_rect(mk(4000, 10, 200, 10));
    send_rect(mk(100, 100, -50, -80));
    send_rect(mk(5000, 0, 10, 10));
    send_rect(mk(4096, 0, 0, 10));
    send_rect(mk(0, 4096, 10, 0));
    send_rect(mk(0, 0, 512, 512));
    send_rect(mk(-10, 0, 458, 576));
    send_rect(mk(-10, 0, 522, 512));
    send_rect(mk(0, 0, 640, 448));
    send_rect(mk(32767, -32768, -32768, 32767));
    send_rect(mk(-32768, 32767, 32767, -32768));
    send_rect(mk(-32768, -32768, -32768, -32768));
    send_rect(mk(32767, 32767, 32767, 32767));
  endtask

  // Register values at and beyond both ends of the legal range, plus a size
  // just past one sector so that the column count changes the index.
  task automatic test_register_extremes();
    set_landscape(13'd0, 13'd8191);
    send_rect(mk(0, 0, 1, 1));
    send_rect(mk(0, 100, 5, 200));
    send_rect(mk(1, 0, 0, 0));
    set_landscape(13'd8191, 13'd0);
    send_rect(mk(4095, 0, 1, 1));
    send_rect(mk(0, 0, 4096, 1));
    set_landscape(13'd65, 13'd65);
    send_rect(mk(0, 0, 65, 65));
    send_rect(mk(64, 64, 1, 1));
  endtask

  task automatic test_random_rects(input int count, input logic [rtsb_pkg::CFG_W-1:0] wd,
                                   input logic [rtsb_pkg::CFG_W-1:0] ht);
    set_landscape(wd, ht);
    repeat (count) send_rect(random_rect());
  endtask

  // A stretch with both sides always ready, so the walk runs at full rate.
  task automatic test_full_rate(input int count);
    set_landscape(13'd4096, 13'd4096);
    no_idle = 1'b1;
    repeat (count) send_rect(random_rect());
    wait_for_results();
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_directed_cases();
    test_register_extremes();
    test_random_rects(30, 13'd4096, 13'd4096);
    test_random_rects(15, 13'd1000, 13'd300);
    test_random_rects(10, 13'd65, 13'd4096);
    test_random_rects(10, 13'd100, 13'd70);
    test_random_rects(10, 13'd8191, 13'd1);
    test_full_rate(20);
    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_sectors.size() != 0) begin
      report_error($sformatf("%0d expected sectors never arrived", pending_sectors.size()));
    end
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // The sink holds stall high or low for stretches of random length.
  always @(posedge clk) begin
    if (stall_hold > 0) begin
      stall_hold <= stall_hold - 1;
    end else begin
      sector_stall <= !no_idle && ($urandom_range(0, 2) == 0);
      stall_hold <= idle_length();
    end
  end

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) begin
      report_error($sformatf("sector %0d: %s is %0d, expected %0d",
                             sector_count, name, got, want));
    end
  endtask

  // Every sector transfer is matched against the oldest sector still owed.
  always @(posedge clk) begin
    rtsb_pkg::sector_t want;
    if (!rst && sector_valid && !sector_stall) begin
      if (pending_sectors.size() == 0) begin
        report_error($sformatf("sector %0d arrived with none expected", sector_count));
      end else begin
        want = pending_sectors.pop_front();
        check_field("sector_index", sector.sector_index, want.sector_index);
        check_field("sector_column", sector.sector_column, want.sector_column);
        check_field("sector_row", sector.sector_row, want.sector_row);
        check_field("outside", sector.outside, want.outside);
        check_field("last", sector.last, want.last);
        check_field("truncated", sector.truncated, want.truncated);
      end
      sector_count++;
    end
  end

  // The run is stopped if neither channel makes a transfer for too long.
  always @(posedge clk) begin
    if (rst || (rect_valid && !rect_stall) || (sector_valid && !sector_stall)) begin
      idle_count <= 0;
    end else if (idle_count >= IDLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_count <= idle_count + 1;
    end
  end

endmodule
